// ----- hw/rtl/ukf_pkg.sv -----
// Shared types and codes for the unique-key FIFO.
// No dependencies; compile first.
`default_nettype none

package ukf_pkg;

    localparam int OP_W     = 2;
    localparam int KEY_W    = 32;
    localparam int PAY_W    = 32;
    localparam int STATUS_W = 2;

    typedef logic        [OP_W-1:0]     op_t;
    typedef logic signed [KEY_W-1:0]    key_t;
    typedef logic        [PAY_W-1:0]    pay_t;
    typedef logic        [STATUS_W-1:0] status_t;

    localparam op_t OP_PUSH   = 2'd0;
    localparam op_t OP_POP    = 2'd1;
    localparam op_t OP_SEARCH = 2'd2;

    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_DUP   = 2'd1;
    localparam status_t ST_EMPTY = 2'd2;
    localparam status_t ST_FULL  = 2'd3;

endpackage

`default_nettype wire

// ----- hw/rtl/ukf_if.sv -----
// Request and response channel interfaces for the unique-key FIFO.
// Depends on ukf_pkg.
`default_nettype none

interface ukf_req_if
    import ukf_pkg::*;
();
    logic valid;
    logic ready;
    op_t  op;
    key_t key;
    pay_t payload;

    modport source (output valid, output op, output key, output payload, input ready);
    modport sink   (input valid, input op, input key, input payload, output ready);
endinterface

interface ukf_rsp_if
    import ukf_pkg::*;
#(
    parameter int CNT_W = 5
)();
    logic             valid;
    logic             ready;
    status_t          status;
    logic             found;
    key_t             out_key;
    pay_t             out_payload;
    logic [CNT_W-1:0] occupancy;

    modport source (output valid, output status, output found, output out_key,
                    output out_payload, output occupancy, input ready);
    modport sink   (input valid, input status, input found, input out_key,
                    input out_payload, input occupancy, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/unique_key_fifo.sv -----
// Channel | Dir | Contents
// --------+-----+---------------------------------------------------
// req     | in  | op, key, payload (push, pop or search request)
// rsp     | out | status, found, out_key, out_payload, occupancy
//
// One request at a time. Push and search read the stored keys one per cycle
// from the key memory, oldest first, and stop at the first match or after
// the last record. Pop reads the head record before it answers; other
// requests and any request on an empty queue go straight to the response.
// Reset clears state, pointers, count and flags; memories need no clearing.
// A stalled response holds in the output register and the next request is
// taken meanwhile; only a second response waits for the register to drain.
// Depends on ukf_pkg and ukf_if.
`default_nettype none

module unique_key_fifo
    import ukf_pkg::*;
#(
    parameter int DEPTH = 16
)(
    input  wire        clk,
    input  wire        rst_n,
    ukf_req_if.sink    req,
    ukf_rsp_if.source  rsp
);

    localparam int AW    = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_POPRD = 2'd2;
    localparam logic [1:0] S_RESP  = 2'd3;

    localparam logic [AW-1:0]    LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    // storage
    logic [KEY_W-1:0] key_mem [DEPTH];
    pay_t             pay_mem [DEPTH];

    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    logic             wr_en;
    logic [KEY_W-1:0] rd_key_reg;
    pay_t             rd_pay_reg;

    // control
    logic [1:0]       state_reg,    state_next;
    logic [AW-1:0]    head_reg,     head_next;
    logic [AW-1:0]    tail_reg,     tail_next;
    logic [CNT_W-1:0] count_reg,    count_next;
    logic [AW-1:0]    scan_pos_reg, scan_pos_next;
    logic [CNT_W-1:0] issued_reg,   issued_next;
    logic             rd_valid_reg, rd_valid_next;
    logic             hit_reg,      hit_next;
    logic             out_valid_reg, out_valid_next;

    // held request
    op_t  op_reg,  op_next;
    key_t key_reg, key_next;
    pay_t pay_reg, pay_next;

    // response register
    status_t          status_reg,  status_next;
    logic             found_reg,   found_next;
    key_t             okey_reg,    okey_next;
    pay_t             opay_reg,    opay_next;
    logic [CNT_W-1:0] occ_reg,     occ_next;

    logic out_free;

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] i);
        logic [AW-1:0] r;
        r = (i == LAST_IDX) ? '0 : i + 1'b1;
        return r;
    endfunction

    assign out_free  = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == S_IDLE);

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = status_reg;
    assign rsp.found       = found_reg;
    assign rsp.out_key     = okey_reg;
    assign rsp.out_payload = opay_reg;
    assign rsp.occupancy   = occ_reg;

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        scan_pos_next  = scan_pos_reg;
        issued_next    = issued_reg;
        rd_valid_next  = rd_valid_reg;
        hit_next       = hit_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        pay_next       = pay_reg;
        status_next    = status_reg;
        found_next     = found_reg;
        okey_next      = okey_reg;
        opay_next      = opay_reg;
        occ_next       = occ_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        rd_en          = 1'b0;
        rd_addr        = head_reg;
        wr_en          = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next       = req.op;
                    key_next      = req.key;
                    pay_next      = req.payload;
                    hit_next      = 1'b0;
                    scan_pos_next = head_reg;
                    issued_next   = '0;
                    rd_valid_next = 1'b0;
                    case (req.op)
                        OP_PUSH, OP_SEARCH:
                            state_next = (count_reg == '0) ? S_RESP : S_SCAN;
                        OP_POP:
                        begin
                            if (count_reg != '0)
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = head_reg;
                                state_next = S_POPRD;
                            end
                            else
                            begin
                                state_next = S_RESP;
                            end
                        end
                        default:
                            state_next = S_RESP;
                    endcase
                end
            end

            S_SCAN:
            begin
                // issue one read per cycle, compare the one that came back
                rd_valid_next = 1'b0;
                if (issued_reg != count_reg)
                begin
                    rd_en         = 1'b1;
                    rd_addr       = scan_pos_reg;
                    scan_pos_next = wrap_inc(scan_pos_reg);
                    issued_next   = issued_reg + 1'b1;
                    rd_valid_next = 1'b1;
                end
                if (rd_valid_reg && (rd_key_reg == key_reg))
                begin
                    hit_next   = 1'b1;
                    state_next = S_RESP;
                end
                else if ((issued_reg == count_reg) && !rd_valid_reg)
                begin
                    state_next = S_RESP;
                end
            end

            S_POPRD:
                state_next = S_RESP;

            S_RESP:
            begin
                if (out_free)
                begin
                    status_next    = ST_OK;
                    found_next     = 1'b0;
                    okey_next      = '0;
                    opay_next      = '0;
                    case (op_reg)
                        OP_PUSH:
                        begin
                            if (hit_reg)
                            begin
                                status_next = ST_DUP;
                            end
                            else if (count_reg == FULL_CNT)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                tail_next  = wrap_inc(tail_reg);
                                count_next = count_reg + 1'b1;
                            end
                        end
                        OP_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                                okey_next   = '1;
                            end
                            else
                            begin
                                okey_next  = key_t'(rd_key_reg);
                                opay_next  = rd_pay_reg;
                                head_next  = wrap_inc(head_reg);
                                count_next = count_reg - 1'b1;
                            end
                        end
                        OP_SEARCH:
                            found_next = hit_reg;
                        default:
                            status_next = ST_OK;
                    endcase
                    occ_next       = count_next;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    // memories: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_mem[tail_reg] <= key_reg;
            pay_mem[tail_reg] <= pay_reg;
        end
        if (rd_en)
        begin
            rd_key_reg <= key_mem[rd_addr];
            rd_pay_reg <= pay_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            issued_reg    <= '0;
            rd_valid_reg  <= 1'b0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            issued_reg    <= issued_next;
            rd_valid_reg  <= rd_valid_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_pos_reg <= scan_pos_next;
        op_reg       <= op_next;
        key_reg      <= key_next;
        pay_reg      <= pay_next;
        status_reg   <= status_next;
        found_reg    <= found_next;
        okey_reg     <= okey_next;
        opay_reg     <= opay_next;
        occ_reg      <= occ_next;
    end

endmodule

`default_nettype wire

// ----- hw/rtl/ukf_checker.sv -----
// Port-level assertions for the unique-key FIFO, bound to the top level.
// Depends on ukf_pkg and unique_key_fifo.
`default_nettype none

module ukf_checker
    import ukf_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int CNT_W = 5
)(
    input wire             clk,
    input wire             rst_n,
    input wire             req_valid,
    input wire             req_ready,
    input wire             rsp_valid,
    input wire             rsp_ready,
    input wire [1:0]       rsp_status,
    input wire [31:0]      rsp_out_key,
    input wire [CNT_W-1:0] rsp_occupancy
);

    // hold a stalled response
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_occupancy))
        else $error("response dropped or changed while stalled");

    // one request in flight: ready drops after an accept
    a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while another in flight");

    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status == ST_EMPTY) |->
            (rsp_occupancy == '0) && (rsp_out_key == '1))
        else $error("empty status with records held or wrong key");

    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status == ST_FULL) |-> (rsp_occupancy == CNT_W'(DEPTH)))
        else $error("full status below capacity");

endmodule

bind unique_key_fifo ukf_checker #(
    .DEPTH (DEPTH),
    .CNT_W ($clog2(DEPTH + 1))
) u_ukf_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .rsp_status    (rsp.status),
    .rsp_out_key   (rsp.out_key),
    .rsp_occupancy (rsp.occupancy)
);

`default_nettype wire
